>>> hw/rtl/mwo_pkg.sv
package mwo_pkg;

  // run length and sample format
  localparam int MAX_RUN     = 64;
  localparam int CNT_W       = $clog2(MAX_RUN + 1);
  localparam int SAMPLE_BITS = 16;
  localparam int SAMPLE_DROP = (SAMPLE_BITS < 16) ? (16 - SAMPLE_BITS) : 0;
  localparam logic [15:0] SAMPLE_MASK = 16'((32'hFFFF << SAMPLE_DROP) & 32'hFFFF);

  // quarter-wave sine table
  localparam int SINE_DEPTH = 256;
  localparam int SINE_LOG2  = $clog2(SINE_DEPTH);
  localparam int SINE_AW    = SINE_LOG2 + 1;
  localparam int SINE_W     = 17;
  localparam int SINE_ROM_BITS = SINE_W * (SINE_DEPTH + 1);
  localparam longint unsigned PI_Q30 = 64'd3373259426;
  localparam longint ONE_Q15 = 64'd32768;

  // noise generator
  localparam logic [31:0] LFSR_TAPS = 32'hD000_0001;
  localparam logic [31:0] LFSR_SEED = 32'h0000_0001;

  // register reset values
  localparam logic [31:0] INC_RESET = 32'd42852281;
  localparam logic [15:0] AMP_RESET = 16'd32768;

  // register map, index = byte address / 4
  typedef enum logic [1:0] {
    REG_WAVEFORM  = 2'd0,
    REG_PHASE_INC = 2'd1,
    REG_AMPLITUDE = 2'd2,
    REG_ENABLE    = 2'd3
  } reg_idx_t;

  // waveform codes
  localparam logic [2:0] WAVE_SINE   = 3'd0;
  localparam logic [2:0] WAVE_SQUARE = 3'd1;
  localparam logic [2:0] WAVE_SAW    = 3'd2;
  localparam logic [2:0] WAVE_TRI    = 3'd3;
  localparam logic [2:0] WAVE_NOISE  = 3'd4;

  // request operation codes
  localparam logic OP_READ = 1'b0;
  localparam logic OP_SEEK = 1'b1;

  // oscillator state word held in the state memory
  typedef struct packed {
    logic [31:0] phase;
    logic [31:0] frame;
    logic [31:0] noise;
  } osc_state_t;

  // one table entry, evaluated while elaborating
  function automatic logic [SINE_W-1:0] sine_entry(input int unsigned k);
    longint unsigned x;
    longint unsigned term;
    longint sum;
    longint v;
    x = (PI_Q30 * longint'(k)) / (2 * SINE_DEPTH);
    term = x;
    sum = longint'(x);
    for (int n = 1; n <= 7; n++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      case (n)
        1: term = term / 6;
        2: term = term / 20;
        3: term = term / 42;
        4: term = term / 72;
        5: term = term / 110;
        6: term = term / 156;
        default: term = term / 210;
      endcase
      if (n % 2 == 1) sum = sum - longint'(term);
      else sum = sum + longint'(term);
    end
    if (sum < 0) sum = 0;
    v = longint'((longint'(sum) * 32768 + (64'd1 << 29)) >>> 30);
    if (v > ONE_Q15) v = ONE_Q15;
    return SINE_W'(v);
  endfunction

  // whole table packed into one constant vector
  function automatic logic [SINE_ROM_BITS-1:0] sine_rom_build();
    logic [SINE_ROM_BITS-1:0] rom;
    rom = '0;
    for (int k = 0; k <= SINE_DEPTH; k++) begin
      rom[SINE_W*k +: SINE_W] = sine_entry(k);
    end
    return rom;
  endfunction

endpackage

>>> hw/rtl/multi_waveform_oscillator_unit.sv
// Tone generator built around a phase accumulator. A read request produces
// a run of min(sample_count, 64) samples at one sample per clock while the
// output side keeps stall low, each one through the second and third stage
// registers and the output register. The next request is taken once the
// last sample of the run has left the first stage. A seek request passes
// through a seek state (one 32x32 multiply for the new phase). Phase, frame
// counter and noise register live in a one-word state memory that is read
// and written back once per sample; after reset an init state loads its
// reset value before the first request is taken. With enable low, requests
// are accepted and produce nothing. Writing the enable register also
// clears phase and frame counter.
module multi_waveform_oscillator_unit import mwo_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  // request channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               operation,
  input  logic [6:0]         sample_count,
  input  logic [31:0]        seek_frame,
  // sample channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] sample,
  output logic [31:0]        frame_index,
  output logic               last,
  // register port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  typedef enum logic [3:0] {
    ST_INIT = 4'b0001,
    ST_IDLE = 4'b0010,
    ST_RUN  = 4'b0100,
    ST_SEEK = 4'b1000
  } fsm_t;

  fsm_t state, state_next;

  // configuration registers
  logic [2:0]  waveform;
  logic [31:0] phase_increment;
  logic [15:0] amplitude;
  logic        enable;

  logic     cfg_wr;
  reg_idx_t cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = reg_idx_t'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      waveform        <= WAVE_SINE;
      phase_increment <= INC_RESET;
      amplitude       <= AMP_RESET;
      enable          <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_WAVEFORM:  waveform        <= pwdata[2:0];
        REG_PHASE_INC: phase_increment <= pwdata;
        REG_AMPLITUDE: amplitude       <= pwdata[15:0];
        REG_ENABLE:    enable          <= pwdata[0];
        default:       ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (cfg_idx)
      REG_WAVEFORM:  prdata = {29'd0, waveform};
      REG_PHASE_INC: prdata = phase_increment;
      REG_AMPLITUDE: prdata = {16'd0, amplitude};
      REG_ENABLE:    prdata = {31'd0, enable};
      default:       prdata = '0;
    endcase
  end

  // state memory, one word, registered read, bypass of the last write
  osc_state_t state_mem [1];
  osc_state_t rd_data;
  osc_state_t wb_data;
  logic       fresh;
  logic       wr_en;
  osc_state_t wr_data;
  osc_state_t cur;

  always_ff @(posedge clk) begin
    if (wr_en) state_mem[0] <= wr_data;
    rd_data <= state_mem[0];
  end

  always_ff @(posedge clk) begin
    if (rst) fresh <= 1'b0;
    else fresh <= wr_en;
    if (wr_en) wb_data <= wr_data;
  end

  assign cur = fresh ? wb_data : rd_data;

  // pipeline advance
  logic adv;
  logic in_acc;
  logic issue;

  assign adv      = !out_valid || !out_stall;
  assign in_stall = (state != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign issue    = (state == ST_RUN) && adv;

  // request capture
  logic [CNT_W-1:0] cnt_left;
  logic [31:0]      seek_target;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt_left <= '0;
    end else if (in_acc) begin
      cnt_left <= (sample_count > 7'(MAX_RUN)) ? CNT_W'(MAX_RUN) : CNT_W'(sample_count);
    end else if (issue) begin
      cnt_left <= cnt_left - 1'b1;
    end
    if (in_acc) seek_target <= seek_frame;
  end

  // control sequencer
  always_comb begin
    state_next = state;
    case (state)
      ST_INIT: state_next = ST_IDLE;
      ST_IDLE: begin
        if (in_acc && enable) begin
          if (operation == OP_SEEK) state_next = ST_SEEK;
          else if (sample_count != 7'd0) state_next = ST_RUN;
        end
      end
      ST_RUN:  if (issue && cnt_left == CNT_W'(1)) state_next = ST_IDLE;
      ST_SEEK: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_INIT;
    else state <= state_next;
  end

  // first stage: table address, other waveforms, state update
  logic [SINE_LOG2-1:0] pos;
  logic [SINE_AW-1:0]   sine_idx;
  logic [31:0]          noise_step;
  logic signed [16:0]   saw17;
  logic signed [16:0]   abs17;
  logic signed [17:0]   tri18;
  logic signed [16:0]   alt_wave;
  logic [31:0]          seek_phase;

  assign pos      = cur.phase[29 -: SINE_LOG2];
  assign sine_idx = cur.phase[30] ? (SINE_AW'(SINE_DEPTH) - {1'b0, pos}) : {1'b0, pos};
  assign noise_step = {1'b0, cur.noise[31:1]} ^ (cur.noise[0] ? LFSR_TAPS : 32'd0);
  assign saw17 = $signed({cur.phase[31], cur.phase[31:16]});
  assign abs17 = saw17[16] ? -saw17 : saw17;
  assign tri18 = $signed({abs17, 1'b0}) - 18'sd32768;
  assign seek_phase = 32'(seek_target * phase_increment);

  always_comb begin
    case (waveform)
      WAVE_SAW:   alt_wave = saw17;
      WAVE_TRI:   alt_wave = tri18[16:0];
      WAVE_NOISE: alt_wave = $signed({~noise_step[31], ~noise_step[31], noise_step[30:16]});
      default:    alt_wave = '0;
    endcase
  end

  // state memory write source
  always_comb begin
    wr_en   = 1'b0;
    wr_data = cur;
    if (state == ST_INIT) begin
      wr_en   = 1'b1;
      wr_data = '{phase: 32'd0, frame: 32'd0, noise: LFSR_SEED};
    end else if (cfg_wr && cfg_idx == REG_ENABLE) begin
      wr_en   = 1'b1;
      wr_data = '{phase: 32'd0, frame: 32'd0, noise: cur.noise};
    end else if (state == ST_SEEK) begin
      wr_en   = 1'b1;
      wr_data = '{phase: seek_phase, frame: seek_target, noise: cur.noise};
    end else if (issue) begin
      wr_en   = 1'b1;
      wr_data.phase = cur.phase + phase_increment;
      wr_data.frame = cur.frame + 32'd1;
      wr_data.noise = (waveform == WAVE_NOISE) ? noise_step : cur.noise;
    end
  end

  // second stage: table read and waveform select
  localparam logic [SINE_ROM_BITS-1:0] SINE_ROM = sine_rom_build();

  logic [SINE_W-1:0]  rom_q;
  logic               b_valid;
  logic               b_neg;
  logic [2:0]         b_wave;
  logic signed [16:0] b_alt;
  logic [31:0]        b_frame;
  logic               b_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (adv) begin
      b_valid <= issue;
    end
    if (adv) begin
      rom_q   <= SINE_ROM[SINE_W * int'(sine_idx) +: SINE_W];
      b_neg   <= cur.phase[31];
      b_wave  <= waveform;
      b_alt   <= alt_wave;
      b_frame <= cur.frame;
      b_last  <= (cnt_left == CNT_W'(1));
    end
  end

  logic signed [16:0] b_sine;
  logic signed [16:0] b_square;
  logic signed [16:0] b_wave_val;
  logic signed [16:0] gain;
  logic signed [33:0] prod;

  assign b_sine   = b_neg ? -$signed(rom_q) : $signed(rom_q);
  assign b_square = (!b_neg || rom_q == '0) ? 17'sd32768 : -17'sd32768;
  assign gain     = (amplitude > 16'd32768) ? 17'sd32768 : $signed({1'b0, amplitude});

  always_comb begin
    case (b_wave)
      WAVE_SINE:   b_wave_val = b_sine;
      WAVE_SQUARE: b_wave_val = b_square;
      default:     b_wave_val = b_alt;
    endcase
  end

  assign prod = b_wave_val * gain;

  // third stage: gain product
  logic               c_valid;
  logic signed [33:0] c_prod;
  logic [31:0]        c_frame;
  logic               c_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (adv) begin
      c_valid <= b_valid;
    end
    if (adv) begin
      c_prod  <= prod;
      c_frame <= b_frame;
      c_last  <= b_last;
    end
  end

  // rounding and clamp to Q1.15
  logic signed [34:0] rnd;
  logic signed [19:0] scaled;
  logic [15:0]        clamped;

  assign rnd    = 35'(c_prod) + 35'sd16384;
  assign scaled = rnd[34:15];

  always_comb begin
    if (scaled > 20'sd32767) clamped = 16'h7FFF;
    else if (scaled < -20'sd32768) clamped = 16'h8000;
    else clamped = scaled[15:0];
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= c_valid;
    end
    if (adv) begin
      sample      <= $signed(clamped & SAMPLE_MASK);
      frame_index <= c_frame;
      last        <= c_last;
    end
  end

  // checks
  a_run_has_work: assert property (@(posedge clk) disable iff (rst)
    state == ST_RUN |-> cnt_left != '0)
    else $error("run state with no samples left");

  a_read_starts_run: assert property (@(posedge clk) disable iff (rst)
    in_acc && enable && operation == OP_READ && sample_count != 7'd0 |=> state == ST_RUN)
    else $error("accepted read did not start a run");

  a_no_write_on_stall: assert property (@(posedge clk) disable iff (rst)
    state == ST_RUN && !adv && !cfg_wr |-> !wr_en)
    else $error("state memory written while the run is stalled");

  a_last_ends_run: assert property (@(posedge clk) disable iff (rst)
    issue && cnt_left == CNT_W'(1) |=> state == ST_IDLE && b_valid && b_last)
    else $error("final sample did not close the run");

endmodule
